// ===== rtl/vertex_attribute_remap_top_macros.svh =====
// ---------------------------------------------------------------------------
// vertex_attribute_remap_top_macros
// Assertion macros shared by the vertex attribute remap RTL.
// ---------------------------------------------------------------------------
`ifndef VERTEX_ATTRIBUTE_REMAP_TOP_MACROS_SVH
`define VERTEX_ATTRIBUTE_REMAP_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// check with reset disable
`define VA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds in reset
`define VA_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VA_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define VA_ASSERT(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/vamap_pkg.sv =====
// ---------------------------------------------------------------------------
// vamap_pkg
// Shared widths and default sizes for the vertex attribute remap block.
// ---------------------------------------------------------------------------
package vamap_pkg;

    // fixed field widths
    localparam int POS_W       = 12;
    localparam int ATTR_PORT_W = 16;
    localparam int VTX_W       = 13;

    // default table sizes
    localparam int DEF_MAX_VERTICES    = 4096;
    localparam int DEF_REMAP_ENTRIES   = 1024;
    localparam int DEF_ATTR_INDEX_BITS = 16;

    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [ATTR_PORT_W-1:0] t_attr;
    typedef logic [VTX_W-1:0]       t_vtx;

endpackage

// ===== rtl/vamap_ram.sv =====
// ---------------------------------------------------------------------------
// vamap_ram
// Generic single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module vamap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, old data on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vamap_ctrl.sv =====
// ---------------------------------------------------------------------------
// vamap_ctrl
// Sequencer: clearing sweep, hashed remap probe with linear probing,
// per-vertex first pair check and the read-modify-write of both tables.
// ---------------------------------------------------------------------------
`include "vertex_attribute_remap_top_macros.svh"

module vamap_ctrl
    import vamap_pkg::*;
#(
    parameter int MAX_VERTICES    = DEF_MAX_VERTICES,
    parameter int REMAP_ENTRIES   = DEF_REMAP_ENTRIES,
    parameter int ATTR_INDEX_BITS = DEF_ATTR_INDEX_BITS,
    localparam int VIDX_W = $clog2(MAX_VERTICES),
    localparam int RIDX_W = $clog2(REMAP_ENTRIES),
    localparam int A_W    = (ATTR_INDEX_BITS < ATTR_PORT_W) ? ATTR_INDEX_BITS : ATTR_PORT_W,
    localparam int VW_W   = 1 + 2 * A_W,
    localparam int RW_W   = 1 + POS_W + 2 * A_W + VTX_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_pos              i_position_vertex,
    input  t_attr             i_normal_index,
    input  t_attr             i_tex_index,
    input  logic              i_cfg_we,
    input  t_vtx              i_cfg_wdata,
    // per-vertex table port
    output logic [VIDX_W-1:0] o_vt_addr,
    output logic              o_vt_we,
    output logic [VW_W-1:0]   o_vt_wdata,
    input  logic [VW_W-1:0]   i_vt_rdata,
    // remap table port
    output logic [RIDX_W-1:0] o_rm_addr,
    output logic              o_rm_we,
    output logic [RW_W-1:0]   o_rm_wdata,
    input  logic [RW_W-1:0]   i_rm_rdata,
    // result
    output logic              o_done,
    output t_vtx              o_out_vertex,
    output logic              o_write_record,
    output logic              o_is_duplicate,
    output t_pos              o_record_position,
    output t_attr             o_record_normal,
    output t_attr             o_record_tex,
    output logic              o_table_full
);

    localparam int KEY_W = POS_W + 2 * A_W;
    localparam int CNT_W = $clog2(REMAP_ENTRIES + 1);
    localparam int CLR_N = (MAX_VERTICES > REMAP_ENTRIES) ? MAX_VERTICES : REMAP_ENTRIES;
    localparam int CLR_W = $clog2(CLR_N);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    localparam logic [RIDX_W-1:0] LAST_SLOT = RIDX_W'(REMAP_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(REMAP_ENTRIES);

    logic [1:0]        r_state, n_state;
    logic [CLR_W-1:0]  r_clr, n_clr;
    t_pos              r_v, n_v;
    logic [A_W-1:0]    r_n, n_n, r_t, n_t;
    logic [RIDX_W-1:0] r_idx, n_idx, r_probes, n_probes;
    logic [CNT_W-1:0]  r_used, n_used;
    t_vtx              r_next, n_next;

    logic  r_done, n_done;
    t_vtx  r_out, n_out;
    logic  r_wr, n_wr, r_dup, n_dup, r_full, n_full;

    logic [A_W-1:0]    in_n, in_t;
    logic [KEY_W-1:0]  key;
    logic [RIDX_W-1:0] fold, hash, step_idx;

    logic              rm_valid, vt_valid, in_range;
    t_pos              rm_v;
    logic [A_W-1:0]    rm_n, rm_t, vt_n, vt_t;
    t_vtx              rm_tgt;
    logic              hit, step;

    // attributes masked to the configured index width
    assign in_n = A_W'(i_normal_index);
    assign in_t = A_W'(i_tex_index);
    assign key  = {i_position_vertex, in_n, in_t};

    // xor fold of the full triple into a slot index
    always_comb begin
        fold = '0;
        for (int i = 0; i < KEY_W; i++) begin
            fold[i % RIDX_W] = fold[i % RIDX_W] ^ key[i];
        end
    end

    assign hash = (32'(fold) >= REMAP_ENTRIES) ? (fold - LAST_SLOT - 1'b1) : fold;

    // field split of the read words
    assign rm_valid = i_rm_rdata[RW_W-1];
    assign rm_v     = i_rm_rdata[RW_W-2 -: POS_W];
    assign rm_n     = i_rm_rdata[VTX_W + 2*A_W - 1 -: A_W];
    assign rm_t     = i_rm_rdata[VTX_W + A_W - 1 -: A_W];
    assign rm_tgt   = i_rm_rdata[VTX_W-1:0];
    assign vt_valid = i_vt_rdata[VW_W-1];
    assign vt_n     = i_vt_rdata[2*A_W-1 -: A_W];
    assign vt_t     = i_vt_rdata[A_W-1:0];

    // probe decisions
    assign in_range = 32'(r_v) < MAX_VERTICES;
    assign hit      = rm_valid && (rm_v == r_v) && (rm_n == r_n) && (rm_t == r_t);
    assign step     = rm_valid && !hit && (r_probes != LAST_SLOT);
    assign step_idx = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;

    // sequencer and table updates
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_v        = r_v;
        n_n        = r_n;
        n_t        = r_t;
        n_idx      = r_idx;
        n_probes   = r_probes;
        n_used     = r_used;
        n_next     = r_next;
        n_done     = 1'b0;
        n_out      = r_out;
        n_wr       = r_wr;
        n_dup      = r_dup;
        n_full     = r_full;
        o_vt_addr  = VIDX_W'(r_v);
        o_vt_we    = 1'b0;
        o_vt_wdata = {1'b1, r_n, r_t};
        o_rm_addr  = r_idx;
        o_rm_we    = 1'b0;
        o_rm_wdata = {1'b1, r_v, r_n, r_t, r_next};

        case (r_state)
            S_CLEAR: begin
                o_vt_addr  = VIDX_W'(r_clr);
                o_rm_addr  = RIDX_W'(r_clr);
                o_vt_we    = 32'(r_clr) < MAX_VERTICES;
                o_rm_we    = 32'(r_clr) < REMAP_ENTRIES;
                o_vt_wdata = '0;
                o_rm_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_vt_addr = VIDX_W'(i_position_vertex);
                o_rm_addr = hash;
                if (start) begin
                    n_v      = i_position_vertex;
                    n_n      = in_n;
                    n_t      = in_t;
                    n_idx    = hash;
                    n_probes = '0;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                n_out  = t_vtx'(r_v);
                n_wr   = 1'b0;
                n_dup  = 1'b0;
                n_full = 1'b0;
                if (in_range && !hit && step) begin
                    // collision, move to the next slot
                    o_rm_addr = step_idx;
                    n_idx     = step_idx;
                    n_probes  = r_probes + 1'b1;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (!in_range) begin
                        n_out = t_vtx'(r_v);
                    end else if (hit) begin
                        n_out = rm_tgt;
                    end else if (!vt_valid) begin
                        // first sight of this vertex
                        o_vt_we = 1'b1;
                        n_wr    = 1'b1;
                    end else if ((vt_n != r_n) || (vt_t != r_t)) begin
                        if (r_used != FULL_CNT) begin
                            // new duplicate into the empty slot
                            o_rm_we = 1'b1;
                            n_out   = r_next;
                            n_wr    = 1'b1;
                            n_dup   = 1'b1;
                            n_next  = r_next + 1'b1;
                            n_used  = r_used + 1'b1;
                        end else begin
                            n_full = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write loads the allocation pointer
        if (i_cfg_we) begin
            n_next = i_cfg_wdata;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_used  <= '0;
            r_next  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_used  <= n_used;
            r_next  <= n_next;
            r_done  <= n_done;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_n      <= n_n;
        r_t      <= n_t;
        r_idx    <= n_idx;
        r_probes <= n_probes;
        r_out    <= n_out;
        r_wr     <= n_wr;
        r_dup    <= n_dup;
        r_full   <= n_full;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_out_vertex      = r_out;
    assign o_write_record    = r_wr;
    assign o_is_duplicate    = r_dup;
    assign o_table_full      = r_full;
    assign o_record_position = r_wr ? r_v : '0;
    assign o_record_normal   = r_wr ? ATTR_PORT_W'(r_n) : '0;
    assign o_record_tex      = r_wr ? ATTR_PORT_W'(r_t) : '0;

    // checks
    `VA_ASSERT_RST(a_used_bound, i_clk, i_rst_n, r_used <= FULL_CNT, "remap fill count overflow")
    `VA_ASSERT_RST(a_done_after_probe, i_clk, i_rst_n, r_done |-> $past(r_state == S_PROBE), "result without probe")
    `VA_ASSERT_RST(a_dup_writes, i_clk, i_rst_n, (r_done && r_dup) |-> (r_wr && !r_full), "duplicate without record")
    `VA_ASSERT_RST(a_used_moves, i_clk, i_rst_n, (r_state != S_CLEAR && $past(r_state) != S_CLEAR && r_used != $past(r_used)) |-> (r_done && r_dup), "fill count moved without insert")

endmodule

// ===== rtl/vertex_attribute_remap_top.sv =====
// ---------------------------------------------------------------------------
// vertex_attribute_remap_top
// Face corner vertex deduplication: per-vertex first attribute pair table and
// a hashed remap table of duplicated (vertex, normal, texture) triples.
//
//   channel   | ports                                        | handshake
//   ----------+----------------------------------------------+-------------------
//   request   | i_position_vertex, i_normal_index, i_tex_index | start && !busy
//   result    | o_out_vertex, o_write_record, o_is_duplicate, | o_done, one cycle
//             | o_record_position/normal/tex, o_table_full    |
//   register  | i_cfg_wdata (vertex_count)                    | i_cfg_we
//
// A request enters the probe state, which steps to the next remap slot on each
// hash collision; the probe loop over the remap RAM read port sets the rate, and
// a new request waits for busy low. The result strobe comes in the cycle after
// the last probe, and busy is already low then. After reset a clearing sweep of
// max(MAX_VERTICES, REMAP_ENTRIES) entries (4096 by default) holds busy high;
// register writes are taken throughout. The receiver cannot stall the result.
// ---------------------------------------------------------------------------
module vertex_attribute_remap_top
    import vamap_pkg::*;
#(
    parameter int MAX_VERTICES    = DEF_MAX_VERTICES,
    parameter int REMAP_ENTRIES   = DEF_REMAP_ENTRIES,
    parameter int ATTR_INDEX_BITS = DEF_ATTR_INDEX_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_pos  i_position_vertex,
    input  t_attr i_normal_index,
    input  t_attr i_tex_index,
    input  logic  i_cfg_we,
    input  t_vtx  i_cfg_wdata,
    output logic  o_done,
    output t_vtx  o_out_vertex,
    output logic  o_write_record,
    output logic  o_is_duplicate,
    output t_pos  o_record_position,
    output t_attr o_record_normal,
    output t_attr o_record_tex,
    output logic  o_table_full
);

    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int RIDX_W = $clog2(REMAP_ENTRIES);
    localparam int A_W    = (ATTR_INDEX_BITS < ATTR_PORT_W) ? ATTR_INDEX_BITS : ATTR_PORT_W;
    localparam int VW_W   = 1 + 2 * A_W;
    localparam int RW_W   = 1 + POS_W + 2 * A_W + VTX_W;

    logic [VIDX_W-1:0] vt_addr;
    logic              vt_we;
    logic [VW_W-1:0]   vt_wdata, vt_rdata;
    logic [RIDX_W-1:0] rm_addr;
    logic              rm_we;
    logic [RW_W-1:0]   rm_wdata, rm_rdata;

    // sequencer
    vamap_ctrl #(
        .MAX_VERTICES    (MAX_VERTICES),
        .REMAP_ENTRIES   (REMAP_ENTRIES),
        .ATTR_INDEX_BITS (ATTR_INDEX_BITS)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_position_vertex (i_position_vertex),
        .i_normal_index    (i_normal_index),
        .i_tex_index       (i_tex_index),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_vt_addr         (vt_addr),
        .o_vt_we           (vt_we),
        .o_vt_wdata        (vt_wdata),
        .i_vt_rdata        (vt_rdata),
        .o_rm_addr         (rm_addr),
        .o_rm_we           (rm_we),
        .o_rm_wdata        (rm_wdata),
        .i_rm_rdata        (rm_rdata),
        .o_done            (o_done),
        .o_out_vertex      (o_out_vertex),
        .o_write_record    (o_write_record),
        .o_is_duplicate    (o_is_duplicate),
        .o_record_position (o_record_position),
        .o_record_normal   (o_record_normal),
        .o_record_tex      (o_record_tex),
        .o_table_full      (o_table_full)
    );

    // per-vertex first pair table: valid, normal, texture
    vamap_ram #(
        .WIDTH (VW_W),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk   (i_clk),
        .i_addr  (vt_addr),
        .i_we    (vt_we),
        .i_wdata (vt_wdata),
        .o_rdata (vt_rdata)
    );

    // remap table: valid, key triple, target index
    vamap_ram #(
        .WIDTH (RW_W),
        .DEPTH (REMAP_ENTRIES)
    ) u_remap_ram (
        .i_clk   (i_clk),
        .i_addr  (rm_addr),
        .i_we    (rm_we),
        .i_wdata (rm_wdata),
        .o_rdata (rm_rdata)
    );

endmodule
